// File: src/sorted_priority_queue_core_assert.svh
// assertion helpers shared by the queue modules
// both expect a clock named i_clk in scope; SPQ_ASSERT also expects an active-low reset named i_rst_n
`ifndef SORTED_PRIORITY_QUEUE_CORE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_CORE_ASSERT_SVH

// checked only outside reset
`define SPQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// checked at every edge, for reset behaviour
`define SPQ_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error(msg);

`endif

// File: src/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Operation and status codes, and the command and status bundles that join
// the queue controller to its datapath.
// ----------------------------------------------------------------------------
package spq_pkg;

    // operation codes
    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_PEEK   = 2'd1;
    localparam logic [1:0] FUNC_POP    = 2'd2;
    localparam logic [1:0] FUNC_CLEAR  = 2'd3;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // memory read address select
    localparam logic [1:0] RD_NONE  = 2'd0;
    localparam logic [1:0] RD_FRONT = 2'd1;
    localparam logic [1:0] RD_LAST  = 2'd2;
    localparam logic [1:0] RD_PREV  = 2'd3;

    // memory write select
    localparam logic [1:0] WR_NONE      = 2'd0;
    localparam logic [1:0] WR_SHIFT     = 2'd1;
    localparam logic [1:0] WR_NEW_ABOVE = 2'd2;
    localparam logic [1:0] WR_NEW_FRONT = 2'd3;

    // entry count update
    localparam logic [1:0] CNT_HOLD = 2'd0;
    localparam logic [1:0] CNT_INC  = 2'd1;
    localparam logic [1:0] CNT_DEC  = 2'd2;
    localparam logic [1:0] CNT_CLR  = 2'd3;

    typedef struct packed {
        logic       capture;
        logic [1:0] rd_sel;
        logic [1:0] wr_sel;
        logic [1:0] cnt_op;
        logic       res_load;
        logic       res_data;
        logic [1:0] res_status;
    } t_dp_cmd;

    typedef struct packed {
        logic count_zero;
        logic count_full;
        logic idx_zero;
        logic entry_ge;
        logic out_valid;
    } t_dp_status;

endpackage

// File: src/spq_ram.sv
// ----------------------------------------------------------------------------
// spq_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module spq_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: src/spq_ctrl.sv
// ----------------------------------------------------------------------------
// spq_ctrl
// Sequencer for the queue: decodes each operation and steps the insertion
// scan, driving the datapath by command bundle.
// ----------------------------------------------------------------------------
`include "sorted_priority_queue_core_assert.svh"

module spq_ctrl
    import spq_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_func,
    input  logic       i_out_stall,
    input  t_dp_status i_status,
    output logic       o_in_stall,
    output t_dp_cmd    o_cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_RDOUT = 2'd1;
    localparam logic [1:0] S_SCAN  = 2'd2;
    localparam logic [1:0] S_PLACE = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       accept;

    // one operation in flight; the result register must be free or draining
    assign o_in_stall = (r_state != S_IDLE) || (i_status.out_valid && i_out_stall);
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        n_state = r_state;
        o_cmd   = '{capture: 1'b0, rd_sel: RD_NONE, wr_sel: WR_NONE, cnt_op: CNT_HOLD,
                    res_load: 1'b0, res_data: 1'b0, res_status: ST_OK};
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.capture = 1'b1;
                    unique case (i_func)
                        FUNC_INSERT: begin
                            if (i_status.count_full) begin
                                o_cmd.res_load   = 1'b1;
                                o_cmd.res_status = ST_FULL;
                            end else if (i_status.count_zero) begin
                                n_state = S_PLACE;
                            end else begin
                                o_cmd.rd_sel = RD_LAST;
                                n_state      = S_SCAN;
                            end
                        end
                        FUNC_PEEK: begin
                            if (i_status.count_zero) begin
                                o_cmd.res_load   = 1'b1;
                                o_cmd.res_status = ST_EMPTY;
                            end else begin
                                o_cmd.rd_sel = RD_FRONT;
                                n_state      = S_RDOUT;
                            end
                        end
                        FUNC_POP: begin
                            if (i_status.count_zero) begin
                                o_cmd.res_load   = 1'b1;
                                o_cmd.res_status = ST_EMPTY;
                            end else begin
                                o_cmd.rd_sel = RD_LAST;
                                o_cmd.cnt_op = CNT_DEC;
                                n_state      = S_RDOUT;
                            end
                        end
                        FUNC_CLEAR: begin
                            o_cmd.cnt_op   = CNT_CLR;
                            o_cmd.res_load = 1'b1;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_RDOUT: begin
                o_cmd.res_load = 1'b1;
                o_cmd.res_data = 1'b1;
                n_state        = S_IDLE;
            end
            S_SCAN: begin
                // walk down from the back, moving up every entry not below the new one
                if (i_status.entry_ge) begin
                    o_cmd.wr_sel = WR_SHIFT;
                    if (i_status.idx_zero) begin
                        n_state = S_PLACE;
                    end else begin
                        o_cmd.rd_sel = RD_PREV;
                    end
                end else begin
                    o_cmd.wr_sel   = WR_NEW_ABOVE;
                    o_cmd.cnt_op   = CNT_INC;
                    o_cmd.res_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_PLACE: begin
                o_cmd.wr_sel   = WR_NEW_FRONT;
                o_cmd.cnt_op   = CNT_INC;
                o_cmd.res_load = 1'b1;
                n_state        = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `SPQ_ASSERT(a_scan_not_empty, (r_state == S_SCAN) |-> !i_status.count_zero, "scan on empty queue")

endmodule

// File: src/spq_datapath.sv
// ----------------------------------------------------------------------------
// spq_datapath
// Sorted entry memory, entry count, scan index, captured request and the
// result register.
// ----------------------------------------------------------------------------
`include "sorted_priority_queue_core_assert.svh"

module spq_datapath
    import spq_pkg::*;
#(
    parameter int DEPTH          = 16,
    parameter int PAYLOAD_WIDTH  = 32,
    parameter int PRIORITY_WIDTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  t_dp_cmd                          i_cmd,
    input  logic [PAYLOAD_WIDTH-1:0]         i_payload,
    input  logic signed [PRIORITY_WIDTH-1:0] i_priority_req,
    input  logic                             i_out_stall,
    output t_dp_status                       o_status,
    output logic                             o_out_valid,
    output logic [PAYLOAD_WIDTH-1:0]         o_payload_out,
    output logic [1:0]                       o_status_code,
    output logic [$clog2(DEPTH+1)-1:0]       o_fill_count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH+1);
    localparam int EW = PAYLOAD_WIDTH + PRIORITY_WIDTH;

    logic [CW-1:0]                    r_count;
    logic [CW-1:0]                    n_count;
    logic [AW-1:0]                    r_idx;
    logic [PAYLOAD_WIDTH-1:0]         r_payload;
    logic signed [PRIORITY_WIDTH-1:0] r_prio;
    logic                             r_out_valid;
    logic [PAYLOAD_WIDTH-1:0]         r_out_payload;
    logic [1:0]                       r_out_status;
    logic [CW-1:0]                    r_out_count;

    logic [AW-1:0]                    last_addr;
    logic                             rd_en;
    logic [AW-1:0]                    rd_addr;
    logic [EW-1:0]                    rd_data;
    logic                             wr_en;
    logic [AW-1:0]                    wr_addr;
    logic [EW-1:0]                    wr_data;
    logic signed [PRIORITY_WIDTH-1:0] rd_prio;

    assign last_addr = AW'(r_count - CW'(1));
    assign rd_prio   = $signed(rd_data[PAYLOAD_WIDTH +: PRIORITY_WIDTH]);

    always_comb begin
        unique case (i_cmd.rd_sel)
            RD_FRONT: rd_addr = '0;
            RD_LAST:  rd_addr = last_addr;
            RD_PREV:  rd_addr = r_idx - AW'(1);
            default:  rd_addr = '0;
        endcase
    end
    assign rd_en = (i_cmd.rd_sel != RD_NONE);

    always_comb begin
        unique case (i_cmd.wr_sel)
            WR_SHIFT: begin
                wr_addr = r_idx + AW'(1);
                wr_data = rd_data;
            end
            WR_NEW_ABOVE: begin
                wr_addr = r_idx + AW'(1);
                wr_data = {r_prio, r_payload};
            end
            WR_NEW_FRONT: begin
                wr_addr = '0;
                wr_data = {r_prio, r_payload};
            end
            default: begin
                wr_addr = '0;
                wr_data = rd_data;
            end
        endcase
    end
    assign wr_en = (i_cmd.wr_sel != WR_NONE);

    spq_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_comb begin
        unique case (i_cmd.cnt_op)
            CNT_INC: n_count = r_count + CW'(1);
            CNT_DEC: n_count = r_count - CW'(1);
            CNT_CLR: n_count = '0;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_cmd.res_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_payload <= i_payload;
            r_prio    <= i_priority_req;
        end
        if (i_cmd.rd_sel == RD_LAST) begin
            r_idx <= last_addr;
        end else if (i_cmd.rd_sel == RD_PREV) begin
            r_idx <= rd_addr;
        end
        if (i_cmd.res_load) begin
            r_out_payload <= i_cmd.res_data ? rd_data[PAYLOAD_WIDTH-1:0] : '0;
            r_out_status  <= i_cmd.res_status;
            r_out_count   <= n_count;
        end
    end

    assign o_status.count_zero = (r_count == '0);
    assign o_status.count_full = (r_count == CW'(DEPTH));
    assign o_status.idx_zero   = (r_idx == '0);
    assign o_status.entry_ge   = (rd_prio >= r_prio);
    assign o_status.out_valid  = r_out_valid;

    assign o_out_valid   = r_out_valid;
    assign o_payload_out = r_out_payload;
    assign o_status_code = r_out_status;
    assign o_fill_count  = r_out_count;

    `SPQ_ASSERT(a_count_in_range, r_count <= CW'(DEPTH), "entry count beyond depth")
    `SPQ_ASSERT(a_no_result_overwrite, i_cmd.res_load |-> !(r_out_valid && i_out_stall), "result overwritten while held")
    `SPQ_ASSERT(a_shift_ports_apart, (wr_en && rd_en) |-> (wr_addr != rd_addr), "read and write collide during shift")
    `SPQ_ASSERT_RST(a_reset_clears, !i_rst_n |=> (!r_out_valid && (r_count == '0)), "reset left state behind")

endmodule

// File: src/sorted_priority_queue_core.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue_core
// Sorted-list priority queue: insert, peek front, pop back and clear.
// ----------------------------------------------------------------------------
// Entries sit in one memory in ascending priority order; an insert goes ahead
// of the first entry of equal or greater priority. One operation is worked at
// a time. Clear, a refused insert and peek or pop on an empty queue finish in
// the accepting state; peek and pop add a registered memory read; an insert
// scans from the back of the queue, moving one entry up per cycle through the
// single write port of the memory.
// A finished result sits in the output register; while the receiver stalls it,
// the next operation is held off. No memory clearing runs after reset.
module sorted_priority_queue_core
    import spq_pkg::*;
#(
    parameter int DEPTH          = 16,
    parameter int PAYLOAD_WIDTH  = 32,
    parameter int PRIORITY_WIDTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [1:0]                       i_func,
    input  logic [PAYLOAD_WIDTH-1:0]         i_payload,
    input  logic signed [PRIORITY_WIDTH-1:0] i_priority_req,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [PAYLOAD_WIDTH-1:0]         o_payload_out,
    output logic [1:0]                       o_status,
    output logic [$clog2(DEPTH+1)-1:0]       o_fill_count
);

    t_dp_cmd    cmd;
    t_dp_status dp_status;

    spq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_func      (i_func),
        .i_out_stall (i_out_stall),
        .i_status    (dp_status),
        .o_in_stall  (o_in_stall),
        .o_cmd       (cmd)
    );

    spq_datapath #(
        .DEPTH          (DEPTH),
        .PAYLOAD_WIDTH  (PAYLOAD_WIDTH),
        .PRIORITY_WIDTH (PRIORITY_WIDTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_payload      (i_payload),
        .i_priority_req (i_priority_req),
        .i_out_stall    (i_out_stall),
        .o_status       (dp_status),
        .o_out_valid    (o_out_valid),
        .o_payload_out  (o_payload_out),
        .o_status_code  (o_status),
        .o_fill_count   (o_fill_count)
    );

endmodule
